### src/assert_macros.svh
// Assertion macros shared by the queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside of reset.
`define BDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Implication: when the antecedent holds, the consequent holds in the next cycle.
`define BDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### src/bdq_pkg.sv
// Types, constants and index helpers for the bounded double-ended queue.
package bdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned PORT_W     = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_CLEAR      = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Which address the element store reads in a given cycle.
  typedef enum logic [1:0] {
    RD_POP   = 2'd0,
    RD_FRONT = 2'd1,
    RD_REAR  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    exec;
    rd_sel_e rd_sel;
    logic    cap_popped;
    logic    cap_front;
    logic    cap_rear;
  } cmd_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) r = '0;
    else                        r = i + IDX_W'(1);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == '0) r = IDX_W'(DEPTH - 1);
    else         r = i - IDX_W'(1);
    return r;
  endfunction

endpackage

### src/bdq_ctrl.sv
// Sequencing state machine for the bounded double-ended queue.
`include "assert_macros.svh"

module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_RDF  = 6'b000100,
    S_RDR  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_RDF;
      S_RDF:  state_d = S_RDR;
      S_RDR:  state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The store has one read port: the popped element, then the new front,
  // then the new rear are read in turn.
  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.exec       = (state_q == S_EXEC);
    cmd_o.rd_sel     = RD_POP;
    cmd_o.cap_popped = (state_q == S_RDF);
    cmd_o.cap_front  = (state_q == S_RDR);
    cmd_o.cap_rear   = (state_q == S_FIN);
    case (state_q)
      S_EXEC:  cmd_o.rd_sel = RD_POP;
      S_RDF:   cmd_o.rd_sel = RD_FRONT;
      S_RDR:   cmd_o.rd_sel = RD_REAR;
      default: cmd_o.rd_sel = RD_POP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BDQ_ASSERT(a_no_accept_while_result, out_valid_o |-> in_stall_o)
  `BDQ_ASSERT_NEXT(a_accept_starts_exec, cmd_o.accept, state_q == S_EXEC)
  `BDQ_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o)

endmodule

### src/bdq_datapath.sv
// Element store, indices, count and result registers of the queue.
`include "assert_macros.svh"

module bdq_datapath
  import bdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [PORT_W-1:0] data_in_i,
  output logic [PORT_W-1:0] popped_value_o,
  output logic [PORT_W-1:0] front_value_o,
  output logic [PORT_W-1:0] rear_value_o,
  output logic [STAT_W-1:0] status_o,
  output logic [LEN_W-1:0]  length_o,
  output logic              is_empty_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [ACT_W-1:0]      action_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [IDX_W-1:0]      front_idx_q, front_idx_d;
  logic [IDX_W-1:0]      rear_idx_q, rear_idx_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  status_e               status_q, status_d;
  logic                  pop_ok_q, pop_ok_d;
  logic [DATA_WIDTH-1:0] popped_q, front_val_q, rear_val_q;

  logic                  full, empty;
  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);

  always_comb begin
    front_idx_d = front_idx_q;
    rear_idx_d  = rear_idx_q;
    cnt_d       = cnt_q;
    status_d    = STAT_DONE;
    pop_ok_d    = 1'b0;
    we          = 1'b0;
    waddr       = rear_idx_q;
    case (action_q)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          front_idx_d = idx_prev(front_idx_q);
          waddr       = front_idx_d;
          we          = 1'b1;
          cnt_d       = cnt_q + CNT_W'(1);
        end
      end
      ACT_PUSH_REAR: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          waddr      = rear_idx_q;
          we         = 1'b1;
          rear_idx_d = idx_next(rear_idx_q);
          cnt_d      = cnt_q + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          pop_ok_d    = 1'b1;
          front_idx_d = idx_next(front_idx_q);
          cnt_d       = cnt_q - CNT_W'(1);
        end
      end
      ACT_POP_REAR: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          pop_ok_d   = 1'b1;
          rear_idx_d = idx_prev(rear_idx_q);
          cnt_d      = cnt_q - CNT_W'(1);
        end
      end
      ACT_CLEAR: begin
        front_idx_d = '0;
        rear_idx_d  = '0;
        cnt_d       = '0;
      end
      default: ;
    endcase
  end

  // In the execute cycle the indices still hold their old values, so the
  // popped element sits at the old front or one below the old rear.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_POP: begin
        if (action_q == ACT_POP_REAR) raddr = idx_prev(rear_idx_q);
        else                          raddr = front_idx_q;
      end
      RD_FRONT: raddr = front_idx_q;
      RD_REAR:  raddr = idx_prev(rear_idx_q);
      default:  raddr = front_idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem_q[waddr] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      data_q   <= DATA_WIDTH'(data_in_i);
    end
    if (cmd_i.cap_popped) popped_q    <= pop_ok_q ? rdata_q : '0;
    if (cmd_i.cap_front)  front_val_q <= empty ? '0 : rdata_q;
    if (cmd_i.cap_rear)   rear_val_q  <= empty ? '0 : rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx_q <= '0;
      rear_idx_q  <= '0;
      cnt_q       <= '0;
      status_q    <= STAT_DONE;
      pop_ok_q    <= 1'b0;
    end else if (cmd_i.exec) begin
      front_idx_q <= front_idx_d;
      rear_idx_q  <= rear_idx_d;
      cnt_q       <= cnt_d;
      status_q    <= status_d;
      pop_ok_q    <= pop_ok_d;
    end
  end

  assign popped_value_o = PORT_W'(popped_q);
  assign front_value_o  = PORT_W'(front_val_q);
  assign rear_value_o   = PORT_W'(rear_val_q);
  assign status_o       = status_q;
  assign length_o       = LEN_W'(cnt_q);
  assign is_empty_o     = empty;

  `BDQ_ASSERT(a_count_bounded, cnt_q <= CNT_W'(DEPTH))
  `BDQ_ASSERT_NEXT(a_full_push_keeps_count,
                   cmd_i.exec && full && (action_q == ACT_PUSH_FRONT ||
                                          action_q == ACT_PUSH_REAR),
                   $stable(cnt_q) && status_q == STAT_FULL)
  `BDQ_ASSERT_NEXT(a_empty_pop_refused,
                   cmd_i.exec && empty && (action_q == ACT_POP_FRONT ||
                                           action_q == ACT_POP_REAR),
                   cnt_q == '0 && !pop_ok_q)

endmodule

### src/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue.
// Each request carries one action (push front, push rear, pop front, pop rear,
// clear) and yields exactly one result: the popped element, the front and rear
// elements afterwards, a status, the length and an empty flag. After acceptance
// a request passes the execute, read-front, read-rear and finish states before
// its result is valid, and the result holds while it is stalled. The next
// request is accepted in the cycle after the result has been taken, so
// requests never overlap. This follows from the single read port of the
// 16-entry element store, which is read three times per request (popped
// element, new front, new rear) through a registered read.
// A push on a full queue reports status 2 and a pop on an empty queue status 1;
// neither changes the queue. No clearing pass follows reset.
module bounded_double_ended_queue
  import bdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [PORT_W-1:0] data_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PORT_W-1:0] popped_value_o,
  output logic [PORT_W-1:0] front_value_o,
  output logic [PORT_W-1:0] rear_value_o,
  output logic [STAT_W-1:0] status_o,
  output logic [LEN_W-1:0]  length_o,
  output logic              is_empty_o
);

  cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bdq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .data_in_i      (data_in_i),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .rear_value_o   (rear_value_o),
    .status_o       (status_o),
    .length_o       (length_o),
    .is_empty_o     (is_empty_o)
  );

endmodule
